// ----- rtl/rpc_pkg.sv -----
package rpc_pkg;

  localparam int NSTG  = 7;
  localparam int IDX_W = 3;

  typedef logic signed [31:0] word_t;
  typedef logic [NSTG-1:0]    stage_en_t;

  typedef struct packed {
    word_t w;
    word_t x;
    word_t y;
    word_t z;
  } quat_t;

  typedef struct packed {
    word_t x;
    word_t y;
    word_t z;
  } vec_t;

  typedef struct packed {
    quat_t q;
    vec_t  t;
  } pose_t;

  typedef enum logic [IDX_W-1:0] {
    REG_BASE_QW = 3'd0,
    REG_BASE_QX = 3'd1,
    REG_BASE_QY = 3'd2,
    REG_BASE_QZ = 3'd3,
    REG_BASE_TX = 3'd4,
    REG_BASE_TY = 3'd5,
    REG_BASE_TZ = 3'd6
  } reg_idx_t;

  localparam word_t BASE_QW_RST = 32'sh4000_0000;

  localparam logic signed [65:0] Q_RND = 66'sd1 <<< 29;
  localparam logic signed [99:0] T_RND = 100'sd1 <<< 58;

  localparam word_t SAT_MAX = 32'sh7fff_ffff;
  localparam word_t SAT_MIN = 32'sh8000_0000;

  // rounded quaternion sum at 2^-60, drop 30 fraction bits and clamp
  function automatic word_t sat_q(input logic signed [65:0] r);
    logic signed [35:0] t;
    t = r[65:30];
    if (t[35:31] == {5{t[35]}}) begin
      return t[31:0];
    end
    return t[35] ? SAT_MIN : SAT_MAX;
  endfunction

  // rounded translation sum at 2^-75, drop 59 fraction bits and clamp
  function automatic word_t sat_t(input logic signed [99:0] r);
    logic signed [40:0] t;
    t = r[99:59];
    if (t[40:31] == {10{t[40]}}) begin
      return t[31:0];
    end
    return t[40] ? SAT_MIN : SAT_MAX;
  endfunction

  function automatic logic signed [63:0] mul32(input word_t a, input word_t b);
    logic signed [63:0] r;
    r = a * b;
    return r;
  endfunction

  function automatic logic signed [64:0] mul33(input logic signed [32:0] a,
                                               input word_t b);
    logic signed [64:0] r;
    r = a * b;
    return r;
  endfunction

endpackage

// ----- rtl/rpc_cfg_regs.sv -----
module rpc_cfg_regs (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [rpc_pkg::IDX_W-1:0] cfg_index,
  input  rpc_pkg::word_t            cfg_data,
  output rpc_pkg::pose_t            base
);
  import rpc_pkg::*;

  pose_t base_r;
  pose_t base_nxt;

  assign cfg_ready = 1'b1;
  assign base      = base_r;

  always_comb begin
    base_nxt = base_r;
    if (cfg_valid) begin
      case (reg_idx_t'(cfg_index))
        REG_BASE_QW: base_nxt.q.w = cfg_data;
        REG_BASE_QX: base_nxt.q.x = cfg_data;
        REG_BASE_QY: base_nxt.q.y = cfg_data;
        REG_BASE_QZ: base_nxt.q.z = cfg_data;
        REG_BASE_TX: base_nxt.t.x = cfg_data;
        REG_BASE_TY: base_nxt.t.y = cfg_data;
        REG_BASE_TZ: base_nxt.t.z = cfg_data;
        default:     base_nxt = base_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r     <= '0;
      base_r.q.w <= BASE_QW_RST;
    end else begin
      base_r <= base_nxt;
    end
  end

endmodule

// ----- rtl/rpc_quat_path.sv -----
module rpc_quat_path (
  input  logic               clk,
  input  rpc_pkg::stage_en_t en,
  input  rpc_pkg::quat_t     in_q,
  input  rpc_pkg::quat_t     base_q,
  output rpc_pkg::quat_t     out_q
);
  import rpc_pkg::*;

  quat_t             b1_r;
  logic signed [63:0] p2_r   [16];
  logic signed [63:0] p2_nxt [16];
  logic signed [65:0] s3_r   [4];
  logic signed [65:0] s3_nxt [4];
  quat_t             q4_r;
  quat_t             q5_r;
  quat_t             q6_r;
  quat_t             q7_r;
  word_t             a_v [4];
  word_t             b_v [4];

  assign a_v[0] = base_q.w;
  assign a_v[1] = base_q.x;
  assign a_v[2] = base_q.y;
  assign a_v[3] = base_q.z;
  assign b_v[0] = b1_r.w;
  assign b_v[1] = b1_r.x;
  assign b_v[2] = b1_r.y;
  assign b_v[3] = b1_r.z;

  // all base-by-incoming component products, index base*4 + incoming
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        p2_nxt[i*4+j] = mul32(a_v[i], b_v[j]);
      end
    end
  end

  // Hamilton product terms, with the rounding half folded in
  always_comb begin
    s3_nxt[0] = Q_RND + 66'(p2_r[0])  - 66'(p2_r[5])  - 66'(p2_r[10]) - 66'(p2_r[15]);
    s3_nxt[1] = Q_RND + 66'(p2_r[1])  + 66'(p2_r[4])  + 66'(p2_r[11]) - 66'(p2_r[14]);
    s3_nxt[2] = Q_RND + 66'(p2_r[2])  - 66'(p2_r[7])  + 66'(p2_r[8])  + 66'(p2_r[13]);
    s3_nxt[3] = Q_RND + 66'(p2_r[3])  + 66'(p2_r[6])  - 66'(p2_r[9])  + 66'(p2_r[12]);
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      b1_r <= in_q;
    end
    if (en[1]) begin
      p2_r <= p2_nxt;
    end
    if (en[2]) begin
      s3_r <= s3_nxt;
    end
    if (en[3]) begin
      q4_r.w <= sat_q(s3_r[0]);
      q4_r.x <= sat_q(s3_r[1]);
      q4_r.y <= sat_q(s3_r[2]);
      q4_r.z <= sat_q(s3_r[3]);
    end
    // hold alongside the translation path
    if (en[4]) begin
      q5_r <= q4_r;
    end
    if (en[5]) begin
      q6_r <= q5_r;
    end
    if (en[6]) begin
      q7_r <= q6_r;
    end
  end

  assign out_q = q7_r;

endmodule

// ----- rtl/rpc_rot_path.sv -----
module rpc_rot_path (
  input  logic               clk,
  input  rpc_pkg::stage_en_t en,
  input  rpc_pkg::vec_t      in_t,
  input  rpc_pkg::pose_t     base,
  output rpc_pkg::vec_t      out_t
);
  import rpc_pkg::*;

  localparam int XX = 0;
  localparam int YY = 1;
  localparam int ZZ = 2;
  localparam int XY = 3;
  localparam int XZ = 4;
  localparam int YZ = 5;
  localparam int WX = 6;
  localparam int WY = 7;
  localparam int WZ = 8;

  vec_t               v1_r;
  word_t              v2_r   [3];
  logic signed [32:0] off2_r [3];
  logic signed [63:0] pp2_r  [9];
  logic signed [63:0] pp2_nxt[9];
  word_t              v3_r   [3];
  logic signed [32:0] off3_r [3];
  logic signed [64:0] m3_r   [9];
  logic signed [64:0] m3_nxt [9];
  logic signed [32:0] off4_r [3];
  logic signed [64:0] lo4_r  [9];
  logic signed [64:0] hi4_r  [9];
  logic signed [64:0] lo4_nxt[9];
  logic signed [64:0] hi4_nxt[9];
  logic signed [32:0] off5_r [3];
  logic signed [66:0] lo5_r  [3];
  logic signed [66:0] hi5_r  [3];
  logic signed [99:0] tot6_r [3];
  vec_t               t7_r;
  word_t              v1_v   [3];
  word_t              bt_v   [3];

  assign v1_v[0] = v1_r.x;
  assign v1_v[1] = v1_r.y;
  assign v1_v[2] = v1_r.z;
  assign bt_v[0] = base.t.x;
  assign bt_v[1] = base.t.y;
  assign bt_v[2] = base.t.z;

  always_comb begin
    pp2_nxt[XX] = mul32(base.q.x, base.q.x);
    pp2_nxt[YY] = mul32(base.q.y, base.q.y);
    pp2_nxt[ZZ] = mul32(base.q.z, base.q.z);
    pp2_nxt[XY] = mul32(base.q.x, base.q.y);
    pp2_nxt[XZ] = mul32(base.q.x, base.q.z);
    pp2_nxt[YZ] = mul32(base.q.y, base.q.z);
    pp2_nxt[WX] = mul32(base.q.w, base.q.x);
    pp2_nxt[WY] = mul32(base.q.w, base.q.y);
    pp2_nxt[WZ] = mul32(base.q.w, base.q.z);
  end

  // rotation matrix less identity, halved: row*3 + column
  always_comb begin
    m3_nxt[0] = -(65'(pp2_r[YY]) + 65'(pp2_r[ZZ]));
    m3_nxt[1] = 65'(pp2_r[XY]) - 65'(pp2_r[WZ]);
    m3_nxt[2] = 65'(pp2_r[WY]) + 65'(pp2_r[XZ]);
    m3_nxt[3] = 65'(pp2_r[XY]) + 65'(pp2_r[WZ]);
    m3_nxt[4] = -(65'(pp2_r[XX]) + 65'(pp2_r[ZZ]));
    m3_nxt[5] = 65'(pp2_r[YZ]) - 65'(pp2_r[WX]);
    m3_nxt[6] = 65'(pp2_r[XZ]) - 65'(pp2_r[WY]);
    m3_nxt[7] = 65'(pp2_r[YZ]) + 65'(pp2_r[WX]);
    m3_nxt[8] = -(65'(pp2_r[XX]) + 65'(pp2_r[YY]));
  end

  // split each coefficient into an unsigned low word and a signed high part
  always_comb begin
    for (int k = 0; k < 9; k++) begin
      lo4_nxt[k] = mul33($signed({1'b0, m3_r[k][31:0]}), v3_r[k%3]);
      hi4_nxt[k] = mul33($signed(m3_r[k][64:32]), v3_r[k%3]);
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      v1_r <= in_t;
    end
    if (en[1]) begin
      pp2_r <= pp2_nxt;
      for (int c = 0; c < 3; c++) begin
        v2_r[c]   <= v1_v[c];
        off2_r[c] <= 33'(v1_v[c]) + 33'(bt_v[c]);
      end
    end
    if (en[2]) begin
      m3_r   <= m3_nxt;
      v3_r   <= v2_r;
      off3_r <= off2_r;
    end
    if (en[3]) begin
      lo4_r  <= lo4_nxt;
      hi4_r  <= hi4_nxt;
      off4_r <= off3_r;
    end
    if (en[4]) begin
      for (int r = 0; r < 3; r++) begin
        lo5_r[r] <= 67'(lo4_r[r*3]) + 67'(lo4_r[r*3+1]) + 67'(lo4_r[r*3+2]);
        hi5_r[r] <= 67'(hi4_r[r*3]) + 67'(hi4_r[r*3+1]) + 67'(hi4_r[r*3+2]);
      end
      off5_r <= off4_r;
    end
    if (en[5]) begin
      for (int r = 0; r < 3; r++) begin
        tot6_r[r] <= (100'(hi5_r[r]) <<< 32) + 100'(lo5_r[r])
                   + (100'(off5_r[r]) <<< 59) + T_RND;
      end
    end
    if (en[6]) begin
      t7_r.x <= sat_t(tot6_r[0]);
      t7_r.y <= sat_t(tot6_r[1]);
      t7_r.z <= sat_t(tot6_r[2]);
    end
  end

  assign out_t = t7_r;

endmodule

// ----- rtl/rigid_pose_compose_core.sv -----
// Composes a base rigid-body pose with each incoming pose.
// Input channel (in_valid/in_ready): one pose per request, quaternion in
// signed Q2.30 and translation in signed Q16.16. Output channel
// (out_valid/out_ready): the composed pose, quaternion = base * incoming,
// translation = base rotation applied to incoming translation plus base
// translation, each field rounded to nearest and saturated.
// Configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data): writes
// base_qw..base_tz at indices 0..6; index 7 is ignored. cfg_ready is always
// high. Write only while no request is in flight.
// out_valid rises once an accepted request has passed through the
// seven register stages (input capture, products, sums, split partial
// products, partial sums, final add, saturation). Throughput: one request
// per cycle while out_ready is high.
// Reset: clears all stage valid bits and loads the identity base pose.
// A stalled receiver holds the output register; stages behind it fill up,
// and in_ready falls only once every stage holds a request.
module rigid_pose_compose_core (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  rpc_pkg::word_t            in_qw,
  input  rpc_pkg::word_t            in_qx,
  input  rpc_pkg::word_t            in_qy,
  input  rpc_pkg::word_t            in_qz,
  input  rpc_pkg::word_t            in_tx,
  input  rpc_pkg::word_t            in_ty,
  input  rpc_pkg::word_t            in_tz,
  output logic                      out_valid,
  input  logic                      out_ready,
  output rpc_pkg::word_t            out_qw,
  output rpc_pkg::word_t            out_qx,
  output rpc_pkg::word_t            out_qy,
  output rpc_pkg::word_t            out_qz,
  output rpc_pkg::word_t            out_tx,
  output rpc_pkg::word_t            out_ty,
  output rpc_pkg::word_t            out_tz,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [rpc_pkg::IDX_W-1:0] cfg_index,
  input  rpc_pkg::word_t            cfg_data
);
  import rpc_pkg::*;

  stage_en_t  vld_r;
  stage_en_t  vld_nxt;
  stage_en_t  en;
  pose_t      base;
  quat_t      in_q;
  vec_t       in_t;
  quat_t      res_q;
  vec_t       res_t;

  // a stage advances when empty or when the stage ahead advances
  always_comb begin
    en[NSTG-1] = !vld_r[NSTG-1] || out_ready;
    for (int k = NSTG - 2; k >= 0; k--) begin
      en[k] = !vld_r[k] || en[k+1];
    end
  end

  always_comb begin
    vld_nxt[0] = en[0] ? in_valid : vld_r[0];
    for (int k = 1; k < NSTG; k++) begin
      vld_nxt[k] = en[k] ? vld_r[k-1] : vld_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_ready  = en[0];
  assign out_valid = vld_r[NSTG-1];

  assign in_q.w = in_qw;
  assign in_q.x = in_qx;
  assign in_q.y = in_qy;
  assign in_q.z = in_qz;
  assign in_t.x = in_tx;
  assign in_t.y = in_ty;
  assign in_t.z = in_tz;

  rpc_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .base      (base)
  );

  rpc_quat_path u_quat (
    .clk    (clk),
    .en     (en),
    .in_q   (in_q),
    .base_q (base.q),
    .out_q  (res_q)
  );

  rpc_rot_path u_rot (
    .clk   (clk),
    .en    (en),
    .in_t  (in_t),
    .base  (base),
    .out_t (res_t)
  );

  assign out_qw = res_q.w;
  assign out_qx = res_q.x;
  assign out_qy = res_q.y;
  assign out_qz = res_q.z;
  assign out_tx = res_t.x;
  assign out_ty = res_t.y;
  assign out_tz = res_t.z;

endmodule
